/* rtl/core/fsws_pkg.sv */
package fsws_pkg;

	// Number formats
	localparam int FRAC_BITS  = 16;
	localparam int Q30_FRAC   = 30;
	localparam int PH_BITS    = 32;
	localparam int TIME_W     = 20;
	localparam int OUT_W      = 19;
	localparam int SHAPE_W    = 2;
	localparam int COUNT_W    = 7;

	// Sizes
	localparam int MAX_TERMS  = 64;
	localparam int SIN_DEPTH  = 1024;
	localparam int SIN_AW     = $clog2(SIN_DEPTH);
	localparam int SIN_HALF   = SIN_DEPTH / 2;
	localparam int SIN_QTR    = SIN_DEPTH / 4;
	localparam int Q_AW       = SIN_AW - 1;
	localparam int K_W        = $clog2(MAX_TERMS);
	localparam int N_W        = $clog2(MAX_TERMS + 1);
	localparam int PW         = FRAC_BITS + PH_BITS;
	localparam int MAG_W      = 31;
	localparam int PROD_W     = 2 * MAG_W;
	localparam int ACC_W      = 36;
	localparam int SH         = Q30_FRAC - FRAC_BITS;
	localparam int R_W        = ACC_W - SH;

	// Configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT = CFG_IDX_W'(1);
	localparam logic [COUNT_W-1:0]   TERM_COUNT_RST = COUNT_W'(10);

	// Wave shapes
	localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = SHAPE_W'(0);
	localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = SHAPE_W'(1);
	localparam logic [SHAPE_W-1:0] SHAPE_SAWTOOTH = SHAPE_W'(2);

	// Q.30 and Q.32 constants
	localparam longint unsigned TWO_PI_Q30        = 64'd6746518852;
	localparam longint unsigned FOUR_OVER_PI_Q30  = 64'd1367130551;
	localparam longint unsigned FOUR_OVER_PI2_Q30 = 64'd435171170;
	localparam longint unsigned TWO_OVER_PI_Q30   = 64'd683565276;
	localparam logic [MAG_W-1:0] INV_PI_Q32       = MAG_W'(1367130551);
	localparam longint          Q30_ONE           = 64'sd1073741824;

	typedef logic [MAG_W-1:0] mag_t;
	typedef mag_t coef_tab_t [MAX_TERMS];
	typedef mag_t qsin_tab_t [SIN_QTR+1];

	// Restoring long division; it is only evaluated while the constant tables are built.
	function automatic longint unsigned udiv(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Sine of a quarter-wave angle given in Q.32 turns, as a truncated Taylor series.
	function automatic mag_t qsine(input longint unsigned a);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned dvs;
		longint          sum;
		x    = (a * TWO_PI_Q30) >> 32;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int n = 1; n <= 8; n++) begin
			dvs  = longint'((2 * n) * (2 * n + 1));
			term = udiv((term * x2) >> 30, dvs);
			if ((n & 1) == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		if (sum > Q30_ONE)
			sum = Q30_ONE;
		return mag_t'(sum);
	endfunction

	function automatic qsin_tab_t build_qsin();
		qsin_tab_t tab;
		longint unsigned a;
		for (int q = 0; q <= SIN_QTR; q++) begin
			a = longint'(q) << (PH_BITS - SIN_AW);
			tab[q] = qsine(a);
		end
		return tab;
	endfunction

	function automatic coef_tab_t build_coef(input logic [SHAPE_W-1:0] shape);
		coef_tab_t tab;
		longint unsigned m;
		for (int k = 0; k < MAX_TERMS; k++) begin
			m = longint'(2 * k + 1);
			if (shape == SHAPE_SQUARE)
				tab[k] = mag_t'(udiv(FOUR_OVER_PI_Q30, m));
			else if (shape == SHAPE_TRIANGLE)
				tab[k] = mag_t'(udiv(FOUR_OVER_PI2_Q30, m * m));
			else if (k == 0)
				tab[k] = '0;
			else
				tab[k] = mag_t'(udiv(TWO_OVER_PI_Q30, longint'(k)));
		end
		return tab;
	endfunction

	localparam qsin_tab_t QSIN_TAB  = build_qsin();
	localparam coef_tab_t COEF_SQ   = build_coef(SHAPE_SQUARE);
	localparam coef_tab_t COEF_TRI  = build_coef(SHAPE_TRIANGLE);
	localparam coef_tab_t COEF_SAW  = build_coef(SHAPE_SAWTOOTH);

	typedef struct packed {
		logic load;
		logic saw;
		logic advance;
	} phase_ctl_t;

	typedef struct packed {
		logic               clear;
		logic               saw;
		logic               setup;
		logic               issue;
		logic [K_W-1:0]     k;
		logic [SHAPE_W-1:0] shape;
	} term_ctl_t;

	typedef struct packed {
		logic                    busy;
		logic signed [OUT_W-1:0] wave;
		logic                    clipped;
	} term_sts_t;

endpackage

/* rtl/core/fsws_time_if.sv */
interface fsws_time_if;
	import fsws_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [TIME_W-1:0] time_value;

	modport source (output valid, output time_value, input ready);
	modport sink (input valid, input time_value, output ready);
endinterface

/* rtl/core/fsws_wave_if.sv */
interface fsws_wave_if;
	import fsws_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] wave_value;
	logic                    clipped;

	modport source (output valid, output wave_value, output clipped, input ready);
	modport sink (input valid, input wave_value, input clipped, output ready);
endinterface

/* rtl/core/fsws_cfg_if.sv */
interface fsws_cfg_if;
	import fsws_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/fsws_phase_gen.sv */
module fsws_phase_gen (
	input  logic                              clk,
	input  fsws_pkg::phase_ctl_t              ctl,
	input  logic signed [fsws_pkg::TIME_W-1:0] t,
	input  logic [fsws_pkg::PROD_W-1:0]       prod,
	output logic [fsws_pkg::SIN_AW-1:0]       idx
);
	import fsws_pkg::*;

	// The phase is kept with FRAC_BITS extra low bits so that the sawtooth
	// step, t/pi in turns, accumulates without loss; the turn fraction is
	// the top PH_BITS bits.
	logic [PW-1:0]     v_q;
	logic [PW-1:0]     step_q;
	logic [PW-1:0]     t_ext;
	logic [PROD_W-1:0] d_full;
	logic [PW-1:0]     d;

	assign t_ext  = PW'(t);
	assign d_full = t[TIME_W-1] ? (~prod + PROD_W'(1)) : prod;
	assign d      = d_full[PW-1:0];
	assign idx    = v_q[PW-1 -: SIN_AW];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (ctl.saw) begin
				v_q    <= d;
				step_q <= d;
			end else begin
				v_q    <= t_ext << PH_BITS;
				step_q <= t_ext << (PH_BITS + 1);
			end
		end else if (ctl.advance) begin
			v_q <= v_q + step_q;
		end
	end

endmodule

/* rtl/core/fsws_term_unit.sv */
module fsws_term_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fsws_pkg::term_ctl_t                ctl,
	input  logic [fsws_pkg::SIN_AW-1:0]        idx,
	input  logic signed [fsws_pkg::TIME_W-1:0] t,
	output logic [fsws_pkg::PROD_W-1:0]        prod,
	output fsws_pkg::term_sts_t                sts
);
	import fsws_pkg::*;

	localparam logic signed [ACC_W-1:0] ACC_HALF  = ACC_W'(1) << (Q30_FRAC - 1);
	localparam logic signed [ACC_W-1:0] ACC_RND   = ACC_W'(1) << (SH - 1);
	localparam logic signed [R_W-1:0]   OUT_MAX_R = R_W'((2 ** (OUT_W - 1)) - 1);
	localparam logic signed [R_W-1:0]   OUT_MIN_R = -(R_W'(2 ** (OUT_W - 1)));

	logic [Q_AW-1:0]     j;
	logic [SIN_AW-1:0]   jx;
	logic [SIN_AW-1:0]   qx;
	logic [Q_AW-1:0]     q;
	mag_t                cmag;
	logic                csgn;
	logic [TIME_W-1:0]   t_mag;
	mag_t                mul_a;
	mag_t                mul_b;

	logic                valid_s1;
	mag_t                qsin_s1;
	logic                sneg_s1;
	mag_t                cmag_s1;
	logic                csgn_s1;

	logic                valid_s2;
	logic [PROD_W-1:0]   prod_s2;
	logic                sgn_s2;

	logic signed [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0]        term_ext;
	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [R_W-1:0]   r;

	// Fold the full-turn table index onto the stored quarter wave.
	assign j  = idx[SIN_AW-2:0];
	assign jx = {1'b0, j};
	assign qx = (jx > SIN_AW'(SIN_QTR)) ? (SIN_AW'(SIN_HALF) - jx) : jx;
	assign q  = qx[Q_AW-1:0];

	always_comb begin
		cmag = '0;
		csgn = 1'b0;
		case (ctl.shape)
			SHAPE_SQUARE: begin
				cmag = COEF_SQ[ctl.k];
			end
			SHAPE_TRIANGLE: begin
				cmag = COEF_TRI[ctl.k];
				csgn = ctl.k[0];
			end
			SHAPE_SAWTOOTH: begin
				cmag = COEF_SAW[ctl.k];
				csgn = ~ctl.k[0];
			end
			default: begin
				cmag = '0;
				csgn = 1'b0;
			end
		endcase
	end

	// The one multiplier also forms |t|/pi in turns before a sawtooth run.
	assign t_mag = t[TIME_W-1] ? (~t + TIME_W'(1)) : t;
	assign mul_a = ctl.setup ? MAG_W'(t_mag) : cmag_s1;
	assign mul_b = ctl.setup ? INV_PI_Q32 : qsin_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctl.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			qsin_s1 <= QSIN_TAB[q];
			sneg_s1 <= idx[SIN_AW-1];
			cmag_s1 <= cmag;
			csgn_s1 <= csgn;
		end
		if (valid_s1 || ctl.setup) begin
			prod_s2 <= mul_a * mul_b;
			sgn_s2  <= sneg_s1 ^ csgn_s1;
		end
	end

	assign term_ext = ACC_W'(prod_s2[Q30_FRAC +: MAG_W]);

	always_ff @(posedge clk) begin
		if (ctl.clear)
			acc_q <= ctl.saw ? ACC_HALF : '0;
		else if (valid_s2)
			acc_q <= sgn_s2 ? (acc_q - $signed(term_ext)) : (acc_q + $signed(term_ext));
	end

	assign acc_rnd = acc_q + ACC_RND;
	assign r       = acc_rnd[ACC_W-1:SH];
	assign prod    = prod_s2;

	always_comb begin
		sts.busy = valid_s1 | valid_s2;
		if (r > OUT_MAX_R) begin
			sts.wave    = OUT_MAX_R[OUT_W-1:0];
			sts.clipped = 1'b1;
		end else if (r < OUT_MIN_R) begin
			sts.wave    = OUT_MIN_R[OUT_W-1:0];
			sts.clipped = 1'b1;
		end else begin
			sts.wave    = r[OUT_W-1:0];
			sts.clipped = 1'b0;
		end
	end

endmodule

/* rtl/core/fourier_series_wave_synth.sv */
// Fourier-series wave synthesizer: each time request returns the partial Fourier sum of the
// selected square, triangle or sawtooth wave at that time, in signed fixed point with 16
// fraction bits, saturated and flagged when clipped. One term is worked per clock through a
// shared phase accumulator, quarter-wave sine table, coefficient table and a single 31x31
// multiplier; a request occupies the block for the term loop (up to N terms, term_count, limited
// to 64) and the drain of the three-stage lookup-multiply-accumulate pipeline; an empty sum or
// the unused shape code skips the term loop. A new time request is taken as soon as the
// previous sum is in the output register, even if that result has not been taken yet.
// Configuration writes are always ready.
module fourier_series_wave_synth (
	input  logic        clk,
	input  logic        arst_n,
	fsws_time_if.sink   sample,
	fsws_wave_if.source wave,
	fsws_cfg_if.sink    cfg
);
	import fsws_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_RUN   = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]               state_q;
	logic [2:0]               state_d;
	logic [SHAPE_W-1:0]       shape_cfg_q;
	logic [COUNT_W-1:0]       count_cfg_q;
	logic [SHAPE_W-1:0]       shape_q;
	logic [N_W-1:0]           n_q;
	logic [K_W-1:0]           k_q;
	logic signed [TIME_W-1:0] t_q;
	logic [N_W-1:0]           n_cfg;
	logic                     accept;
	logic                     cfg_saw;
	logic                     last;
	logic                     out_load;
	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  out_wave_q;
	logic                     out_clip_q;

	phase_ctl_t        pctl;
	term_ctl_t         tctl;
	term_sts_t         sts;
	logic [SIN_AW-1:0] idx;
	logic [PROD_W-1:0] prod;

	assign cfg.ready    = 1'b1;
	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid & sample.ready;
	assign cfg_saw      = (shape_cfg_q == SHAPE_SAWTOOTH);
	assign n_cfg        = (count_cfg_q > COUNT_W'(MAX_TERMS)) ? N_W'(MAX_TERMS)
	                                                          : N_W'(count_cfg_q);
	assign last         = ((N_W'(k_q) + N_W'(1)) == n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_cfg_q <= SHAPE_SQUARE;
			count_cfg_q <= TERM_COUNT_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_WAVE_SHAPE: shape_cfg_q <= cfg.data[SHAPE_W-1:0];
				REG_TERM_COUNT: count_cfg_q <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d      = state_q;
		pctl         = '0;
		tctl         = '0;
		tctl.k       = k_q;
		tctl.shape   = shape_q;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					tctl.clear = 1'b1;
					tctl.saw   = cfg_saw;
					if ((shape_cfg_q inside {SHAPE_SQUARE, SHAPE_TRIANGLE}) && (n_cfg != '0))
						state_d = ST_LOAD;
					else if (cfg_saw && (n_cfg > N_W'(1)))
						state_d = ST_SETUP;
					else
						state_d = ST_DRAIN;
				end
			end
			ST_SETUP: begin
				tctl.setup = 1'b1;
				state_d    = ST_LOAD;
			end
			ST_LOAD: begin
				pctl.load = 1'b1;
				pctl.saw  = (shape_q == SHAPE_SAWTOOTH);
				state_d   = ST_RUN;
			end
			ST_RUN: begin
				tctl.issue   = 1'b1;
				pctl.advance = 1'b1;
				if (last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.busy)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || wave.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				k_q <= cfg_saw ? K_W'(1) : '0;
			else if (state_q == ST_RUN)
				k_q <= k_q + K_W'(1);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (wave.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			t_q     <= sample.time_value;
			shape_q <= shape_cfg_q;
			n_q     <= n_cfg;
		end
		if (out_load) begin
			out_wave_q <= sts.wave;
			out_clip_q <= sts.clipped;
		end
	end

	fsws_phase_gen u_phase (
		.clk  (clk),
		.ctl  (pctl),
		.t    (t_q),
		.prod (prod),
		.idx  (idx)
	);

	fsws_term_unit u_term (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tctl),
		.idx    (idx),
		.t      (t_q),
		.prod   (prod),
		.sts    (sts)
	);

	assign wave.valid      = out_valid_q;
	assign wave.wave_value = out_wave_q;
	assign wave.clipped    = out_clip_q;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
	import fsws_pkg::*;

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] wave;
		logic                    clipped;
	} wave_result_t;

	localparam logic [SHAPE_W-1:0] SHAPE_UNUSED = SHAPE_W'(3);
	localparam int TIME_MIN    = -(1 << (TIME_W - 1));
	localparam int TIME_MAX    = (1 << (TIME_W - 1)) - 1;
	localparam int HOLD_OFF    = 300;
	localparam int STUCK_LIMIT = 5000;
	localparam int SETTLE      = 2 * (MAX_TERMS + 6);

	logic clk;
	logic arst_n;

	fsws_time_if sample_bus ();
	fsws_wave_if wave_bus ();
	fsws_cfg_if  cfg_bus ();

	fourier_series_wave_synth u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_bus),
		.wave   (wave_bus),
		.cfg    (cfg_bus)
	);

	longint                   sine_lut [SIN_DEPTH];
	logic [SHAPE_W-1:0]       cur_shape = SHAPE_SQUARE;
	logic [COUNT_W-1:0]       cur_count = TERM_COUNT_RST;
	logic signed [TIME_W-1:0] pending_times [$];
	wave_result_t             expected_samples [$];
	wave_result_t             want;
	int                       fail_count = 0;
	int                       send_gap = 0;
	int                       recv_gap = 0;
	int                       recv_hold = 0;
	int                       stuck_cycles = 0;
	logic                     quiet = 1'b0;
	logic                     long_stall_go = 1'b0;
	logic                     long_stall_seen = 1'b0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Sine of an angle in the first quarter turn (Q.32 turns in, Q.30 out).
	function automatic longint taylor_quarter(input u64_t ang);
		u64_t   x;
		u64_t   x2;
		u64_t   pw;
		longint acc;
		x   = (ang * TWO_PI_Q30) >> 32;
		x2  = (x * x) >> 30;
		pw  = x;
		acc = longint'(x);
		for (int n = 1; n <= 8; n++) begin
			pw = ((pw * x2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
			if (n % 2 == 1)
				acc = acc - longint'(pw);
			else
				acc = acc + longint'(pw);
		end
		if (acc < 0)
			acc = 0;
		if (acc > Q30_ONE)
			acc = Q30_ONE;
		return acc;
	endfunction

	function automatic wave_result_t synth_sample(input logic signed [TIME_W-1:0] t_in,
			input logic [SHAPE_W-1:0] shape, input logic [COUNT_W-1:0] count);
		wave_result_t res;
		longint       t;
		longint       acc;
		longint       coef;
		longint       sine;
		longint       term;
		longint       rnd;
		u64_t         mc;
		u64_t         ms;
		logic [63:0]  ph;
		logic [SIN_AW-1:0] idx;
		int           n;
		int           first;
		int           odd;
		res = '0;
		if (shape == SHAPE_UNUSED)
			return res;
		t     = t_in;
		n     = (count > MAX_TERMS) ? MAX_TERMS : int'(count);
		acc   = (shape == SHAPE_SAWTOOTH) ? Q30_ONE / 2 : 0;
		first = (shape == SHAPE_SAWTOOTH) ? 1 : 0;
		for (int k = first; k < n; k++) begin
			if (shape == SHAPE_SAWTOOTH) begin
				// Radian argument: k*t/pi turns, kept as a Q.48 fraction of a turn.
				ph   = longint'(k) * t * longint'(INV_PI_Q32);
				idx  = ph[FRAC_BITS + PH_BITS - 1 -: SIN_AW];
				coef = longint'(TWO_OVER_PI_Q30) / longint'(k);
				if (k % 2 == 0)
					coef = -coef;
			end else begin
				odd = 2 * k + 1;
				ph  = longint'(odd) * t;
				idx = ph[FRAC_BITS - 1 -: SIN_AW];
				if (shape == SHAPE_SQUARE) begin
					coef = longint'(FOUR_OVER_PI_Q30) / longint'(odd);
				end else begin
					coef = longint'(FOUR_OVER_PI2_Q30) / longint'(odd * odd);
					if (k % 2 == 1)
						coef = -coef;
				end
			end
			sine = sine_lut[idx];
			mc   = u64_t'(coef < 0 ? -coef : coef);
			ms   = u64_t'(sine < 0 ? -sine : sine);
			term = longint'((mc * ms) >> Q30_FRAC);
			acc  = ((coef < 0) != (sine < 0)) ? acc - term : acc + term;
		end
		rnd = (acc + (longint'(1) <<< (SH - 1))) >>> SH;
		if (rnd > (longint'(1) <<< (OUT_W - 1)) - 1) begin
			rnd = (longint'(1) <<< (OUT_W - 1)) - 1;
			res.clipped = 1'b1;
		end else if (rnd < -(longint'(1) <<< (OUT_W - 1))) begin
			rnd = -(longint'(1) <<< (OUT_W - 1));
			res.clipped = 1'b1;
		end
		res.wave = rnd[OUT_W-1:0];
		return res;
	endfunction

	// Time request driver.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!sample_bus.valid || sample_bus.ready) begin
				if (sample_bus.valid) begin
					expected_samples.push_back(
						synth_sample(sample_bus.time_value, cur_shape, cur_count));
					void'(pending_times.pop_front());
				end
				if (send_gap > 0) begin
					send_gap--;
					sample_bus.valid <= 1'b0;
				end else if (pending_times.size() == 0) begin
					sample_bus.valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 8);
					sample_bus.valid <= 1'b0;
				end else begin
					sample_bus.valid      <= 1'b1;
					sample_bus.time_value <= pending_times[0];
				end
			end
		end
	end

	// Sample monitor and receiver back-pressure.
	always @(posedge clk) begin
		if (arst_n) begin
			if (wave_bus.valid && wave_bus.ready) begin
				if (expected_samples.size() == 0) begin
					$error("sample with no request outstanding: wave_value %0d",
						wave_bus.wave_value);
					fail_count++;
				end else begin
					want = expected_samples.pop_front();
					if (wave_bus.wave_value !== want.wave) begin
						$error("wave_value mismatch: expected %0d, got %0d",
							want.wave, wave_bus.wave_value);
						fail_count++;
					end
					if (wave_bus.clipped !== want.clipped) begin
						$error("clipped mismatch: expected %0b, got %0b",
							want.clipped, wave_bus.clipped);
						fail_count++;
					end
				end
			end
			if (long_stall_go && !long_stall_seen) begin
				recv_hold = HOLD_OFF;
				long_stall_seen = 1'b1;
			end
			if (recv_hold > 0) begin
				recv_hold--;
				wave_bus.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				wave_bus.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 8);
				wave_bus.ready <= 1'b0;
			end else begin
				wave_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && cfg_bus.valid && cfg_bus.ready) begin
			case (cfg_bus.index)
				REG_WAVE_SHAPE: cur_shape <= cfg_bus.data[SHAPE_W-1:0];
				REG_TERM_COUNT: cur_count <= cfg_bus.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((sample_bus.valid && sample_bus.ready) || (wave_bus.valid && wave_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic post_time(input int t);
		pending_times.push_back(TIME_W'(t));
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_times.size() != 0 || expected_samples.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		cfg_bus.valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	// The spare upper bits of the shape word are random; only the low bits count.
	task automatic set_wave(input logic [SHAPE_W-1:0] shape, input int count);
		logic [CFG_DATA_W-1:0] word;
		wait_drained();
		word = CFG_DATA_W'($urandom);
		word[SHAPE_W-1:0] = shape;
		write_reg(REG_WAVE_SHAPE, word);
		write_reg(REG_TERM_COUNT, CFG_DATA_W'(count));
	endtask

	initial begin
		u64_t               ang;
		logic               neg;
		longint             mag;
		int                 t;
		int                 sel;
		logic [SHAPE_W-1:0] shape;
		int                 count;

		arst_n                = 1'b0;
		sample_bus.valid      = 1'b0;
		sample_bus.time_value = '0;
		wave_bus.ready        = 1'b0;
		cfg_bus.valid         = 1'b0;
		cfg_bus.index         = '0;
		cfg_bus.data          = '0;

		for (int i = 0; i < SIN_DEPTH; i++) begin
			ang = u64_t'(i) << (PH_BITS - SIN_AW);
			neg = ang >= (u64_t'(1) << 31);
			if (neg)
				ang = ang - (u64_t'(1) << 31);
			if (ang > (u64_t'(1) << 30))
				ang = (u64_t'(1) << 31) - ang;
			mag = taylor_quarter(ang);
			sine_lut[i] = neg ? -mag : mag;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Settings out of reset: square wave with ten terms.
		post_time(0);
		post_time(16384);
		post_time(TIME_MIN);
		post_time(TIME_MAX);
		post_time(65535);

		set_wave(SHAPE_SQUARE, MAX_TERMS);
		post_time(16384);
		post_time(1);
		post_time(-1);

		set_wave(SHAPE_TRIANGLE, 1);
		post_time(16384);
		set_wave(SHAPE_TRIANGLE, MAX_TERMS);
		post_time(49152);
		post_time(TIME_MAX);
		set_wave(SHAPE_TRIANGLE, 0);
		post_time(16384);

		// With a single term the sawtooth is only its offset.
		set_wave(SHAPE_SAWTOOTH, 1);
		post_time(65536);
		set_wave(SHAPE_SAWTOOTH, 0);
		post_time(12345);
		set_wave(SHAPE_SAWTOOTH, MAX_TERMS);
		post_time(TIME_MIN);
		post_time(TIME_MAX);
		post_time(100000);

		set_wave(SHAPE_SQUARE, 0);
		post_time(16384);
		set_wave(SHAPE_SQUARE, (1 << COUNT_W) - 1);
		post_time(16384);
		set_wave(SHAPE_UNUSED, 5);
		post_time(16384);
		post_time(-1);

		// A write to an index with no register behind it must change nothing.
		wait_drained();
		write_reg(CFG_IDX_W'($urandom_range(REG_TERM_COUNT + 1, (1 << CFG_IDX_W) - 1)),
			CFG_DATA_W'($urandom));
		post_time(16384);
		post_time(-40000);

		for (int p = 0; p < 14; p++) begin
			sel = $urandom_range(0, 9);
			shape = (sel == 9) ? SHAPE_UNUSED : SHAPE_W'(sel % 3);
			case ($urandom_range(0, 7))
				0: count = 1;
				1: count = MAX_TERMS;
				2: count = $urandom_range(MAX_TERMS + 1, (1 << COUNT_W) - 1);
				3: count = 0;
				default: count = $urandom_range(1, 20);
			endcase
			set_wave(shape, count);
			if (p == 13)
				quiet = 1'b1;
			if (p == 4)
				long_stall_go = 1'b1;
			repeat (30) begin
				case ($urandom_range(0, 3))
					0: t = (int'($urandom_range(0, 255)) - 128) * 4096;
					1: t = int'($urandom_range(0, 131072)) - 65536;
					default: t = $urandom;
				endcase
				post_time(t);
			end
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
